/* sv/rc4_pkg.sv */
// Shared types and constants for the RC4 stream cipher unit.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing else.
package rc4_pkg;

   // Field and table sizes.
   localparam int BYTE_W        = 8;
   localparam int KIND_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int KEY_LEN_W     = 9;
   localparam int REQ_DATA_W    = 3 * BYTE_W;
   localparam int TABLE_DEPTH   = 256;
   localparam int MAX_KEY_BYTES = 256;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

   // Item kinds carried in req_tuser.
   typedef enum logic [KIND_W-1:0] {
      KIND_KEY_WRITE = 2'd0,
      KIND_SCHEDULE  = 2'd1,
      KIND_DATA      = 2'd2
   } kind_type;

   // Result status carried in rsp_tuser.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_REJECT     = 2'd1,
      STATUS_NOT_KEYED  = 2'd2
   } status_type;

   // Which result the datapath prepares.
   typedef enum logic [1:0] {
      RES_OK     = 2'd0,
      RES_REJECT = 2'd1,
      RES_PASS   = 2'd2,
      RES_CIPHER = 2'd3
   } res_sel_type;

   // Permutation table write selection.
   typedef enum logic [2:0] {
      WR_NONE  = 3'd0,
      WR_FILL  = 3'd1,
      WR_N_B   = 3'd2,
      WR_I_B   = 3'd3,
      WR_J_SI  = 3'd4
   } wr_sel_type;

   // Permutation table read port A address selection.
   typedef enum logic [1:0] {
      RA_N  = 2'd0,
      RA_I1 = 2'd1,
      RA_T  = 2'd2
   } rd_sel_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'd0,
      ST_FILL   = 4'd1,
      ST_KS_A   = 4'd2,
      ST_KS_B   = 4'd3,
      ST_KS_C   = 4'd4,
      ST_KS_D   = 4'd5,
      ST_PG_A   = 4'd6,
      ST_PG_B   = 4'd7,
      ST_PG_C   = 4'd8,
      ST_PG_D   = 4'd9,
      ST_PG_E   = 4'd10,
      ST_PG_F   = 4'd11,
      ST_RESULT = 4'd12
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        key_write;
      logic        res_set;
      res_sel_type res_sel;
      logic        sched_start;
      wr_sel_type  wr_sel;
      rd_sel_type  rd_a_sel;
      logic        j_step;
      logic        j_use_key;
      logic        n_inc;
      logic        kpos_adv;
      logic        i_inc;
      logic        sched_done;
      logic        rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic keyed;
      logic key_empty;
      logic last_step;
      logic out_free;
   } stat_type;

endpackage

/* sv/rc4_ctrl.sv */
// Controller state machine of the RC4 unit: sequences key writes, the key
// schedule and keystream generation, and issues commands to rc4_dp.
// Depends on rc4_pkg.
module rc4_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  rc4_pkg::kind_type req_kind,
   input  rc4_pkg::stat_type stat,
   output rc4_pkg::cmd_type  cmd
);
   import rc4_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_kind)
                  KIND_SCHEDULE: state_in = stat.key_empty ? ST_RESULT : ST_FILL;
                  KIND_DATA:     state_in = stat.keyed ? ST_PG_A : ST_RESULT;
                  default:       state_in = ST_RESULT;
               endcase
            end
         end
         ST_FILL:   state_in = stat.last_step ? ST_KS_A : ST_FILL;
         ST_KS_A:   state_in = ST_KS_B;
         ST_KS_B:   state_in = ST_KS_C;
         ST_KS_C:   state_in = ST_KS_D;
         ST_KS_D:   state_in = stat.last_step ? ST_RESULT : ST_KS_A;
         ST_PG_A:   state_in = ST_PG_B;
         ST_PG_B:   state_in = ST_PG_C;
         ST_PG_C:   state_in = ST_PG_D;
         ST_PG_D:   state_in = ST_PG_E;
         ST_PG_E:   state_in = ST_PG_F;
         ST_PG_F:   state_in = ST_RESULT;
         ST_RESULT: state_in = stat.out_free ? ST_IDLE : ST_RESULT;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               case (req_kind)
                  KIND_KEY_WRITE: begin
                     cmd.key_write = 1'b1;
                     cmd.res_set   = 1'b1;
                     cmd.res_sel   = RES_OK;
                  end
                  KIND_SCHEDULE: begin
                     if (stat.key_empty) begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_REJECT;
                     end else begin
                        cmd.sched_start = 1'b1;
                     end
                  end
                  KIND_DATA: begin
                     if (!stat.keyed) begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = RES_PASS;
                     end
                  end
                  default: begin
                     cmd.res_set = 1'b1;
                     cmd.res_sel = RES_OK;
                  end
               endcase
            end
         end
         ST_FILL: begin
            cmd.wr_sel = WR_FILL;
            cmd.n_inc  = 1'b1;
         end
         ST_KS_A: begin
            cmd.rd_a_sel = RA_N;
         end
         ST_KS_B: begin
            cmd.j_step    = 1'b1;
            cmd.j_use_key = 1'b1;
         end
         ST_KS_C: begin
            cmd.wr_sel = WR_N_B;
         end
         ST_KS_D: begin
            cmd.wr_sel   = WR_J_SI;
            cmd.n_inc    = 1'b1;
            cmd.kpos_adv = 1'b1;
            if (stat.last_step) begin
               cmd.sched_done = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_sel    = RES_OK;
            end
         end
         ST_PG_A: begin
            cmd.rd_a_sel = RA_I1;
            cmd.i_inc    = 1'b1;
         end
         ST_PG_B: begin
            cmd.j_step = 1'b1;
         end
         ST_PG_C: begin
            cmd.wr_sel = WR_I_B;
         end
         ST_PG_D: begin
            cmd.wr_sel = WR_J_SI;
         end
         ST_PG_E: begin
            cmd.rd_a_sel = RA_T;
         end
         ST_PG_F: begin
            cmd.res_set = 1'b1;
            cmd.res_sel = RES_CIPHER;
         end
         ST_RESULT: begin
            cmd.rsp_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* sv/rc4_dp.sv */
// Datapath of the RC4 unit: key store, permutation table, indices, the
// key length register and the result output register.
// Depends on rc4_pkg; driven by commands from rc4_ctrl.
module rc4_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rc4_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rc4_pkg::KEY_LEN_W-1:0]       csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rc4_pkg::BYTE_W-1:0]          rsp_tdata,
   output logic [rc4_pkg::STATUS_W-1:0]        rsp_tuser,
   input  rc4_pkg::cmd_type                    cmd,
   output rc4_pkg::stat_type                   stat
);
   import rc4_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   // Fields of the incoming word.
   logic [BYTE_W-1:0] in_key_index;
   logic [BYTE_W-1:0] in_key_byte;
   logic [BYTE_W-1:0] in_data_byte;

   assign in_key_index = req_tdata[BYTE_W-1:0];
   assign in_key_byte  = req_tdata[2*BYTE_W-1:BYTE_W];
   assign in_data_byte = req_tdata[3*BYTE_W-1:2*BYTE_W];

   // Config reg, always ready; user must write only while idle, unchecked.
   logic [KEY_LEN_W-1:0] key_len_ff;
   logic [KEY_LEN_W-1:0] key_len_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff <= KEY_LEN_RESET;
      end else if (csr_valid) begin
         key_len_ff <= csr_data;
      end
   end

   assign key_len_eff = (key_len_ff > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                        KEY_LEN_W'(MAX_KEY_BYTES) : key_len_ff;

   // Key store with per-entry valid bits; an unwritten entry reads as zero.
   logic [BYTE_W-1:0] key_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] key_vld_ff;
   logic [BYTE_W-1:0] key_rd_ff;
   logic              key_rd_vld_ff;
   logic [BYTE_W-1:0] key_q;
   logic              key0_nz_ff;
   logic [ADDR_W-1:0] kpos_ff;

   always_ff @(posedge clock) begin
      if (cmd.key_write) begin
         key_mem[in_key_index] <= in_key_byte;
      end
      key_rd_ff <= key_mem[kpos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_vld_ff    <= '0;
         key_rd_vld_ff <= 1'b0;
         key0_nz_ff    <= 1'b0;
      end else begin
         key_rd_vld_ff <= key_vld_ff[kpos_ff];
         if (cmd.key_write) begin
            key_vld_ff[in_key_index] <= 1'b1;
            if (in_key_index == '0) begin
               key0_nz_ff <= (in_key_byte != '0);
            end
         end
      end
   end

   assign key_q = key_rd_vld_ff ? key_rd_ff : '0;

   // Schedule step counter and key position, which wraps at the key length.
   logic [ADDR_W-1:0] n_ff;
   logic [KEY_LEN_W-1:0] kpos_inc;

   assign kpos_inc = {1'b0, kpos_ff} + KEY_LEN_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= '0;
         kpos_ff <= '0;
      end else begin
         if (cmd.sched_start) begin
            n_ff    <= '0;
            kpos_ff <= '0;
         end else begin
            if (cmd.n_inc) begin
               n_ff <= n_ff + ADDR_W'(1);
            end
            if (cmd.kpos_adv) begin
               kpos_ff <= (kpos_inc == key_len_eff) ? '0 : kpos_inc[ADDR_W-1:0];
            end
         end
      end
   end

   // Indices and the swap operands.
   logic [ADDR_W-1:0] i_ff;
   logic [ADDR_W-1:0] j_ff;
   logic [ADDR_W-1:0] j_in;
   logic [BYTE_W-1:0] si_ff;
   logic [BYTE_W-1:0] sj_ff;
   logic              keyed_ff;
   logic [BYTE_W-1:0] rda_q;
   logic [BYTE_W-1:0] rdb_q;

   assign j_in = j_ff + rda_q + (cmd.j_use_key ? key_q : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff     <= '0;
         j_ff     <= '0;
         keyed_ff <= 1'b0;
      end else begin
         if (cmd.sched_start || cmd.sched_done) begin
            i_ff <= '0;
            j_ff <= '0;
         end else begin
            if (cmd.i_inc) begin
               i_ff <= i_ff + ADDR_W'(1);
            end
            if (cmd.j_step) begin
               j_ff <= j_in;
            end
         end
         if (cmd.sched_done) begin
            keyed_ff <= 1'b1;
         end
      end
   end

   // Swap operands need no reset.
   always_ff @(posedge clock) begin
      if (cmd.j_step) begin
         si_ff <= rda_q;
      end
      if (cmd.wr_sel == WR_I_B) begin
         sj_ff <= rdb_q;
      end
   end

   // Permutation table: one write port and two registered read ports.
   logic [BYTE_W-1:0] perm_mem [TABLE_DEPTH];
   logic [ADDR_W-1:0] rda_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              wr_en;
   logic [BYTE_W-1:0] rda_ff;
   logic [BYTE_W-1:0] rdb_ff;

   always_comb begin
      case (cmd.rd_a_sel)
         RA_I1:   rda_addr = i_ff + ADDR_W'(1);
         RA_T:    rda_addr = si_ff + sj_ff;
         default: rda_addr = n_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = n_ff;
      wr_data = rdb_q;
      case (cmd.wr_sel)
         WR_FILL: begin
            wr_addr = n_ff;
            wr_data = n_ff;
         end
         WR_N_B: begin
            wr_addr = n_ff;
            wr_data = rdb_q;
         end
         WR_I_B: begin
            wr_addr = i_ff;
            wr_data = rdb_q;
         end
         WR_J_SI: begin
            wr_addr = j_ff;
            wr_data = si_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      rda_ff <= perm_mem[rda_addr];
      rdb_ff <= perm_mem[j_in];
   end

   assign rda_q = rda_ff;
   assign rdb_q = rdb_ff;

   // Pending result and the captured data byte.
   logic [BYTE_W-1:0]   data_ff;
   logic [BYTE_W-1:0]   res_byte_ff;
   logic [STATUS_W-1:0] res_status_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         data_ff <= in_data_byte;
      end
      if (cmd.res_set) begin
         case (cmd.res_sel)
            RES_REJECT: begin
               res_byte_ff   <= '0;
               res_status_ff <= STATUS_REJECT;
            end
            RES_PASS: begin
               res_byte_ff   <= in_data_byte;
               res_status_ff <= STATUS_NOT_KEYED;
            end
            RES_CIPHER: begin
               res_byte_ff   <= data_ff ^ rda_q;
               res_status_ff <= STATUS_OK;
            end
            default: begin
               res_byte_ff   <= '0;
               res_status_ff <= STATUS_OK;
            end
         endcase
      end
   end

   // Output register toward the result channel.
   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_byte_ff   <= res_byte_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Status toward the controller.
   assign stat.keyed     = keyed_ff;
   assign stat.key_empty = !key0_nz_ff || (key_len_ff == '0);
   assign stat.last_step = (n_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign stat.out_free  = out_free;

endmodule

/* sv/rc4_stream_cipher_unit.sv */
// RC4 stream cipher unit, top level: joins the controller and the datapath.
// A key write passes from acceptance through the pending result register into
// the output register, as does every item that is answered at once: a rejected
// schedule, a data word before keying, and the unused kind. A keyed data item
// steps through PG_A to PG_F, where its result is set. A key schedule loads the
// identity permutation in ST_FILL, then runs 256 swap steps through KS_A to
// KS_D, then loads the result. The unit is ready for the next word in the cycle
// after the result is loaded. The sequence is shaped by the permutation table,
// which has one write port, so every swap takes two separate writes after its
// two reads, and the keystream read waits for the swap to land. One item is
// processed at a time. The next word is accepted as soon as the previous result
// sits in the output register, even if the consumer has not taken it yet. A
// finished result waits until the output register is free. The key store reads
// as all zeros after reset and needs no clearing pass.
// Write key_length only while the unit is idle.
// Depends on rc4_pkg, rc4_ctrl and rc4_dp.
module rc4_stream_cipher_unit (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: key_index [7:0], key_byte [15:8], data_byte [23:16]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rc4_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: kind [1:0]
   input  logic [rc4_pkg::KIND_W-1:0]        req_tuser,
   // rsp_tdata: out_byte [7:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rc4_pkg::BYTE_W-1:0]        rsp_tdata,
   // rsp_tuser: status [1:0]
   output logic [rc4_pkg::STATUS_W-1:0]      rsp_tuser,
   // csr_data: key_length [8:0]
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rc4_pkg::KEY_LEN_W-1:0]     csr_data
);
   import rc4_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   kind_type req_kind;

   assign req_kind = kind_type'(req_tuser);

   // Control sequencer.
   rc4_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_kind),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Storage and arithmetic.
   rc4_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

/* sv/rc4_checker.sv */
// Port-level checks for the RC4 stream cipher unit, bound to its top level.
// Depends on rc4_pkg and rc4_stream_cipher_unit.
module rc4_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rc4_pkg::BYTE_W-1:0]        rsp_tdata,
   input logic [rc4_pkg::STATUS_W-1:0]      rsp_tuser
);
   import rc4_pkg::*;

   logic       req_fire;
   logic       rsp_fire;
   logic [1:0] pend_ff;
   logic [1:0] pend_in;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign pend_in  = pend_ff + 2'(req_fire) - 2'(rsp_fire);

   // Count of accepted words whose result has not been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A waiting result holds steady until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No result appears without an accepted word behind it.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pend_ff != 2'd0)
      else $error("result without a pending word");

   // At most one word in work plus one result waiting.
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many words outstanding");

   // The unit is busy right after it accepts a word.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("accepted a word while busy");

   // A rejected schedule carries a zero byte.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_REJECT |-> rsp_tdata == '0)
      else $error("rejected schedule with nonzero byte");

endmodule

bind rc4_stream_cipher_unit rc4_checker u_rc4_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the RC4 stream cipher unit: key writes, key schedules
// and cipher words are predicted by an in-bench RC4 model and compared per field.
// Depends on rc4_pkg and rc4_stream_cipher_unit.
module tb;
   import rc4_pkg::*;

   // The unused item kind has no name in the package.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_WORDS_PER_PHASE = 430;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      status_type        status;
   } cipher_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // req_tdata: key_index [7:0], key_byte [15:8], data_byte [23:16]
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   // req_tuser: kind [1:0]
   logic [KIND_W-1:0]       req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // rsp_tdata: out_byte [7:0]
   logic [BYTE_W-1:0]       rsp_tdata;
   // rsp_tuser: status [1:0]
   logic [STATUS_W-1:0]     rsp_tuser;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [KEY_LEN_W-1:0]    csr_data = '0;

   // Predicted cipher state.
   logic [BYTE_W-1:0]       sbox_q [TABLE_DEPTH];
   logic [BYTE_W-1:0]       key_bytes_q [TABLE_DEPTH];
   logic [BYTE_W-1:0]       prga_i;
   logic [BYTE_W-1:0]       prga_j;
   logic                    keyed_q;
   logic [KEY_LEN_W-1:0]    key_len_q;

   cipher_result_type       expected_results[$];
   int                      mismatch_count = 0;
   int                      words_sent = 0;
   int                      send_idle_pct = 0;
   int                      recv_stall_pct = 0;
   logic                    hold_token = 1'b0;
   logic                    hold_seen = 1'b0;
   int                      hold_left = 0;

   rc4_stream_cipher_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Hard stop in case the unit hangs.
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------

   // State right after reset.
   function automatic void clear_prediction();
      int n;
      for (n = 0; n < TABLE_DEPTH; n++) begin
         sbox_q[n] = n[7:0];
         key_bytes_q[n] = '0;
      end
      prga_i = '0;
      prga_j = '0;
      keyed_q = 1'b0;
      key_len_q = KEY_LEN_RESET;
   endfunction

   function automatic void swap_sbox(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] t;
      t = sbox_q[a];
      sbox_q[a] = sbox_q[b];
      sbox_q[b] = t;
   endfunction

   // Key schedule; an empty key leaves every part of the state alone.
   function automatic status_type predict_schedule();
      int unsigned span;
      int unsigned kpos;
      int n;
      logic [BYTE_W-1:0] jj;
      if (key_bytes_q[0] == '0 || key_len_q == '0) begin
         return STATUS_REJECT;
      end
      span = 32'(key_len_q);
      if (span > MAX_KEY_BYTES) begin
         span = MAX_KEY_BYTES;
      end
      for (n = 0; n < TABLE_DEPTH; n++) begin
         sbox_q[n] = n[7:0];
      end
      prga_i = '0;
      prga_j = '0;
      jj = '0;
      kpos = 0;
      for (n = 0; n < TABLE_DEPTH; n++) begin
         jj = key_bytes_q[kpos] + sbox_q[n] + jj;
         swap_sbox(n[7:0], jj);
         kpos = (kpos + 1) % span;
      end
      keyed_q = 1'b1;
      return STATUS_OK;
   endfunction

   // Next keystream byte; indices and swaps carry over between words.
   function automatic logic [BYTE_W-1:0] predict_keystream();
      logic [BYTE_W-1:0] sum;
      prga_i = prga_i + 8'd1;
      prga_j = prga_j + sbox_q[prga_i];
      swap_sbox(prga_i, prga_j);
      sum = sbox_q[prga_i] + sbox_q[prga_j];
      return sbox_q[sum];
   endfunction

   function automatic cipher_result_type predict_word(input logic [KIND_W-1:0] kind,
                                                      input logic [BYTE_W-1:0] kidx,
                                                      input logic [BYTE_W-1:0] kbyte,
                                                      input logic [BYTE_W-1:0] dbyte);
      cipher_result_type res;
      res.out_byte = '0;
      res.status = STATUS_OK;
      case (kind)
         KIND_KEY_WRITE: begin
            key_bytes_q[kidx] = kbyte;
         end
         KIND_SCHEDULE: begin
            res.status = predict_schedule();
         end
         KIND_DATA: begin
            if (keyed_q) begin
               res.out_byte = dbyte ^ predict_keystream();
            end else begin
               res.out_byte = dbyte;
               res.status = STATUS_NOT_KEYED;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic void report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // ---------------------------------------------------------------
   // Result side: check each word taken, then decide readiness.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      cipher_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result word: out_byte %02h status %0d",
                                      rsp_tdata, rsp_tuser));
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_tdata !== exp_res.out_byte) begin
               report_mismatch($sformatf("out_byte mismatch: expected %02h, got %02h",
                                         exp_res.out_byte, rsp_tdata));
            end
            if (rsp_tuser !== exp_res.status) begin
               report_mismatch($sformatf("status mismatch: expected %0d, got %0d",
                                         exp_res.status, rsp_tuser));
            end
         end
      end
      // A flip of hold_token starts a long hold-off counted here.
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------

   // Offer one word, wait for it to be taken, then record its expected result.
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] kidx,
                            input logic [BYTE_W-1:0] kbyte, input logic [BYTE_W-1:0] dbyte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {dbyte, kbyte, kidx};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_word(kind, kidx, kbyte, dbyte));
      words_sent++;
   endtask

   task automatic write_key_byte(input logic [BYTE_W-1:0] idx, input logic [BYTE_W-1:0] val);
      send_word(KIND_KEY_WRITE, idx, val, 8'($urandom_range(255)));
   endtask

   task automatic start_schedule();
      send_word(KIND_SCHEDULE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
   endtask

   task automatic cipher_byte(input logic [BYTE_W-1:0] d);
      send_word(KIND_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)), d);
   endtask

   // Stop offering and wait until every expected word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Only called with the unit idle.
   task automatic write_key_length(input logic [KEY_LEN_W-1:0] len);
      csr_valid <= 1'b1;
      csr_data <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      key_len_q = len;
   endtask

   function automatic void set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      recv_stall_pct = receiver_pct;
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Data before any schedule passes through; the cleared key store is an empty key.
   task automatic test_before_keying();
      cipher_byte(8'h00);
      cipher_byte(8'hFF);
      send_word(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF);
      start_schedule();
      cipher_byte(8'h5A);
   endtask

   // The classic three-byte key, plus a write to the last key store entry.
   task automatic test_known_key();
      drain_results();
      write_key_length(9'd3);
      write_key_byte(8'd0, 8'h4B);
      write_key_byte(8'd1, 8'h65);
      write_key_byte(8'd2, 8'h79);
      write_key_byte(8'hFF, 8'hFF);
      start_schedule();
      cipher_byte(8'h50);
      cipher_byte(8'h6C);
      cipher_byte(8'h61);
      cipher_byte(8'h69);
      cipher_byte(8'h6E);
   endtask

   // Zero length rejects and keeps the stream going; oversize lengths clamp.
   task automatic test_key_length_limits();
      drain_results();
      write_key_length('0);
      start_schedule();
      cipher_byte(8'($urandom_range(255)));
      drain_results();
      write_key_length('1);
      start_schedule();
      cipher_byte(8'($urandom_range(255)));
      drain_results();
      write_key_length(KEY_LEN_W'(MAX_KEY_BYTES));
      start_schedule();
      cipher_byte(8'($urandom_range(255)));
      drain_results();
      write_key_length(9'd1);
      start_schedule();
      cipher_byte(8'($urandom_range(255)));
   endtask

   // The receiver holds off for a long stretch while data words keep coming.
   task automatic test_output_backpressure();
      drain_results();
      hold_token <= ~hold_token;
      repeat (24) cipher_byte(8'($urandom_range(255)));
      drain_results();
   endtask

   // Mostly complete key/schedule/data sequences, with some loose words mixed in.
   task automatic test_random_traffic(input int budget);
      int first;
      int pick;
      int span;
      int k;
      logic [KEY_LEN_W-1:0] new_len;
      logic [BYTE_W-1:0] kb;
      logic [KIND_W-1:0] kind;
      first = words_sent;
      while (words_sent - first < budget) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            drain_results();
            pick = $urandom_range(99);
            if (pick < 60) begin
               new_len = KEY_LEN_W'($urandom_range(16, 1));
            end else if (pick < 72) begin
               new_len = KEY_LEN_W'($urandom_range(255, 17));
            end else if (pick < 80) begin
               new_len = KEY_LEN_W'(MAX_KEY_BYTES);
            end else if (pick < 88) begin
               new_len = KEY_LEN_W'($urandom_range(511, 257));
            end else if (pick < 93) begin
               new_len = '0;
            end else begin
               new_len = key_len_q;
            end
            write_key_length(new_len);
            // Long keys get only their head rewritten; the rest keeps older bytes.
            span = int'(new_len);
            span = (span > 24) ? 24 : ((span == 0) ? 1 : span);
            for (k = 0; k < span; k++) begin
               kb = 8'($urandom_range(255));
               if (k == 0) begin
                  kb = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
               end
               write_key_byte(k[7:0], kb);
            end
            start_schedule();
            repeat ($urandom_range(40, 1)) cipher_byte(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(12, 1)) begin
               pick = $urandom_range(99);
               if (pick < 40) begin
                  kind = KIND_KEY_WRITE;
               end else if (pick < 85) begin
                  kind = KIND_DATA;
               end else if (pick < 95) begin
                  kind = KIND_UNUSED;
               end else begin
                  kind = KIND_SCHEDULE;
               end
               send_word(kind, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            end
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------
   initial begin
      clear_prediction();
      set_idling(9, 79);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_before_keying();
      test_known_key();
      test_key_length_limits();
      test_random_traffic(RANDOM_WORDS_PER_PHASE);

      drain_results();
      set_idling(79, 9);
      test_random_traffic(RANDOM_WORDS_PER_PHASE);

      drain_results();
      set_idling(0, 0);
      test_output_backpressure();
      test_random_traffic(RANDOM_WORDS_PER_PHASE);

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
